/* rtl/pda_pkg.sv */
// ----------------------------------------------------------------------------
// pda_pkg
// Shared types and constants for the pack delta apply block.
// ----------------------------------------------------------------------------
package pda_pkg;

	localparam int BASE_BYTES  = 512;
	localparam int CHUNK_BYTES = 8;
	localparam int ADDR_W      = $clog2(BASE_BYTES);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int CNT_W       = 4;
	localparam int CMDQ_DEPTH  = 4;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_DELTA  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BASE_SIZE = 3'd1;
	localparam logic [2:0] ST_OP_ZERO   = 3'd2;
	localparam logic [2:0] ST_COPY_PAST = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;
	localparam logic [2:0] ST_TGT_SIZE  = 3'd5;
	localparam logic [2:0] ST_BASE_OVF  = 3'd6;

	typedef enum logic [2:0] {
		PH_BASE_HDR,
		PH_TGT_HDR,
		PH_OPCODE,
		PH_OPERANDS,
		PH_LITERAL,
		PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_EMIT,
		CMD_COPY
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_COPY
	} bk_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [63:0]        data;
		logic [CNT_W-1:0]   count;
		logic               last;
		logic [2:0]         status;
		logic [ADDR_W-1:0]  addr;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef struct packed {
		logic [63:0]      bytes;
		logic [CNT_W-1:0] count;
		logic             last;
		logic [2:0]       status;
	} res_t;

endpackage

/* rtl/pda_front.sv */
// ----------------------------------------------------------------------------
// pda_front
// Parses base loads and delta bytes, checks them and issues commands.
// ----------------------------------------------------------------------------
module pda_front import pda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	input  logic       end_of_delta,
	output logic       cmd_push,
	output cmd_t       cmd
);

	phase_t            phase_q, phase_n;
	logic [63:0]       accum_q, accum_n;
	logic [6:0]        shift_q, shift_n;
	logic [63:0]       decl_q, decl_n;
	logic [63:0]       prod_q, prod_n;
	logic [6:0]        mask_q, mask_n;
	logic [31:0]       off_q, off_n;
	logic [23:0]       clen_q, clen_n;
	logic [6:0]        left_q, left_n;
	logic [63:0]       chunk_q, chunk_n;
	logic [CNT_W-1:0]  fill_q, fill_n;
	logic [LEN_W-1:0]  blen_q, blen_n;
	logic              ovf_q, ovf_n;

	logic [63:0]       acc_f;
	logic [2:0]        err;
	logic              do_cp;
	logic [31:0]       cp_off;
	logic [23:0]       cp_clen;
	logic [24:0]       cp_len;
	logic [2:0]        bit_sel;
	logic [6:0]        mask_w;
	logic [63:0]       chunk_w;
	logic [CNT_W-1:0]  fill_w;
	logic [6:0]        left_w;
	logic [2:0]        eod_st;
	logic              clear;

	// Parse one transaction
	always_comb begin
		phase_n = phase_q;
		accum_n = accum_q;
		shift_n = shift_q;
		decl_n  = decl_q;
		prod_n  = prod_q;
		mask_n  = mask_q;
		off_n   = off_q;
		clen_n  = clen_q;
		left_n  = left_q;
		chunk_n = chunk_q;
		fill_n  = fill_q;
		blen_n  = blen_q;
		ovf_n   = ovf_q;
		cmd_push = 1'b0;
		cmd      = '0;
		cmd.kind = CMD_EMIT;
		err     = ST_OK;
		do_cp   = 1'b0;
		cp_off  = '0;
		cp_clen = '0;
		cp_len  = '0;
		bit_sel = '0;
		mask_w  = '0;
		chunk_w = '0;
		fill_w  = '0;
		left_w  = '0;
		eod_st  = ST_OK;
		clear   = 1'b0;
		acc_f   = accum_q;
		if (shift_q < 7'd64) begin
			acc_f = accum_q | (64'(data_byte[6:0]) << shift_q[5:0]);
		end

		if (accept) begin
			case (action)
				ACT_START: begin
					blen_n = '0;
					ovf_n  = 1'b0;
					clear  = 1'b1;
				end
				ACT_APPEND: begin
					if (blen_q < LEN_W'(BASE_BYTES)) begin
						cmd_push      = 1'b1;
						cmd.kind      = CMD_WRITE;
						cmd.data      = 64'(data_byte);
						cmd.addr      = blen_q[ADDR_W-1:0];
						blen_n        = blen_q + LEN_W'(1);
					end else begin
						ovf_n = 1'b1;
					end
					clear = 1'b1;
				end
				ACT_DELTA: begin
					if (phase_q == PH_DISCARD) begin
						clear = end_of_delta;
					end else begin
						case (phase_q)
							PH_BASE_HDR, PH_TGT_HDR: begin
								if (!data_byte[7]) begin
									accum_n = '0;
									shift_n = '0;
									if (phase_q == PH_BASE_HDR) begin
										clen_n  = ovf_q ? 24'(ST_BASE_OVF) :
											(acc_f != 64'(blen_q) ? 24'(ST_BASE_SIZE) : '0);
										phase_n = PH_TGT_HDR;
									end else begin
										err     = clen_q[2:0];
										decl_n  = acc_f;
										prod_n  = '0;
										clen_n  = '0;
										phase_n = PH_OPCODE;
									end
								end else begin
									accum_n = acc_f;
									if (shift_q < 7'd70) begin
										shift_n = shift_q + 7'd7;
									end
								end
							end
							PH_OPCODE: begin
								if (data_byte[7]) begin
									mask_n = data_byte[6:0];
									off_n  = '0;
									clen_n = '0;
									if (data_byte[6:0] == 7'd0) begin
										do_cp = 1'b1;
									end else begin
										phase_n = PH_OPERANDS;
									end
								end else if (data_byte == 8'd0) begin
									err = ST_OP_ZERO;
								end else begin
									left_n  = data_byte[6:0];
									chunk_n = '0;
									fill_n  = '0;
									phase_n = PH_LITERAL;
								end
							end
							PH_OPERANDS: begin
								// pick the lowest selected operand byte
								bit_sel = 3'd6;
								for (int i = 5; i >= 0; i--) begin
									if (mask_q[i]) begin
										bit_sel = 3'(i);
									end
								end
								cp_off  = off_q;
								cp_clen = clen_q;
								if (bit_sel < 3'd4) begin
									cp_off = off_q | (32'(data_byte) << {bit_sel[1:0], 3'b000});
								end else begin
									cp_clen = clen_q |
										(24'(data_byte) << {3'(bit_sel - 3'd4), 3'b000});
								end
								mask_w = mask_q & ~(7'd1 << bit_sel);
								mask_n = mask_w;
								off_n  = cp_off;
								clen_n = cp_clen;
								do_cp  = (mask_w == 7'd0);
							end
							PH_LITERAL: begin
								chunk_w = chunk_q | (64'(data_byte) << {fill_q[2:0], 3'b000});
								fill_w  = fill_q + CNT_W'(1);
								left_w  = left_q - 7'd1;
								left_n  = left_w;
								prod_n  = prod_q + 64'd1;
								if (fill_w == CNT_W'(CHUNK_BYTES) || left_w == 7'd0) begin
									cmd_push   = 1'b1;
									cmd.kind   = CMD_EMIT;
									cmd.data   = chunk_w;
									cmd.count  = fill_w;
									chunk_n    = '0;
									fill_n     = '0;
								end else begin
									chunk_n = chunk_w;
									fill_n  = fill_w;
								end
								if (left_w == 7'd0) begin
									phase_n = PH_OPCODE;
								end
							end
							default: begin
							end
						endcase

						// Check and issue the selected copy
						if (do_cp) begin
							cp_len = (off_n == off_n && clen_n == 24'd0) ? 25'h10000 : 25'(clen_n);
							if (33'(off_n) + 33'(cp_len) > 33'(blen_q)) begin
								err = ST_COPY_PAST;
							end else begin
								cmd_push = 1'b1;
								cmd.kind = CMD_COPY;
								cmd.addr = off_n[ADDR_W-1:0];
								cmd.len  = cp_len[LEN_W-1:0];
								prod_n   = prod_q + 64'(cp_len);
								mask_n   = '0;
								phase_n  = PH_OPCODE;
							end
						end

						// Close the object on error or end of stream
						if (err != ST_OK) begin
							cmd_push   = 1'b1;
							cmd        = '0;
							cmd.kind   = CMD_EMIT;
							cmd.last   = 1'b1;
							cmd.status = err;
							if (end_of_delta) begin
								clear = 1'b1;
							end else begin
								phase_n = PH_DISCARD;
							end
						end else if (end_of_delta) begin
							if (phase_n != PH_OPCODE) begin
								eod_st = ST_TRUNC;
							end else begin
								eod_st = (prod_n == decl_n) ? ST_OK : ST_TGT_SIZE;
							end
							if (!cmd_push) begin
								cmd_push = 1'b1;
								cmd      = '0;
								cmd.kind = CMD_EMIT;
							end
							cmd.last   = 1'b1;
							cmd.status = eod_st;
							clear      = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase

			if (clear) begin
				phase_n = PH_BASE_HDR;
				accum_n = '0;
				shift_n = '0;
				decl_n  = '0;
				prod_n  = '0;
				mask_n  = '0;
				off_n   = '0;
				clen_n  = '0;
				left_n  = '0;
				chunk_n = '0;
				fill_n  = '0;
			end
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BASE_HDR;
			accum_q <= '0;
			shift_q <= '0;
			decl_q  <= '0;
			prod_q  <= '0;
			mask_q  <= '0;
			off_q   <= '0;
			clen_q  <= '0;
			left_q  <= '0;
			chunk_q <= '0;
			fill_q  <= '0;
			blen_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			accum_q <= accum_n;
			shift_q <= shift_n;
			decl_q  <= decl_n;
			prod_q  <= prod_n;
			mask_q  <= mask_n;
			off_q   <= off_n;
			clen_q  <= clen_n;
			left_q  <= left_n;
			chunk_q <= chunk_n;
			fill_q  <= fill_n;
			blen_q  <= blen_n;
			ovf_q   <= ovf_n;
		end
	end

endmodule

/* rtl/pda_cmd_queue.sv */
// ----------------------------------------------------------------------------
// pda_cmd_queue
// Short command queue between the parser and the execution engine.
// ----------------------------------------------------------------------------
module pda_cmd_queue import pda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t                 slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_q, rd_q;
	logic [CMDQ_PTR_W:0]   cnt_q;
	logic                  do_push, do_pop;

	assign full    = (cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + CMDQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(do_pop);
		end
	end

endmodule

/* rtl/pda_back.sv */
// ----------------------------------------------------------------------------
// pda_back
// Executes commands: base store writes, literal chunks and copies read from
// the store one byte a cycle, into a two-entry result queue while it has room.
// ----------------------------------------------------------------------------
module pda_back import pda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic pop,
	output logic empty,
	output res_t head
);

	logic [7:0]        mem_q [BASE_BYTES];
	logic [7:0]        rdata_q;
	bk_state_t         state_q, state_n;

	logic [ADDR_W-1:0] rd_addr_q;
	logic [LEN_W-1:0]  issue_q, left_q;
	logic              rv_q;
	logic [63:0]       chunk_q;
	logic [CNT_W-1:0]  fill_q;
	logic              cp_last_q;
	logic [2:0]        cp_status_q;

	res_t              rq_q [2];
	logic              rq_wr_q, rq_rd_q;
	logic [1:0]        rq_cnt_q;
	logic              out_full;

	logic              res_push;
	res_t              res_in;
	logic              wr_en, rd_en, consume, stall, fin, done_chunk, load;
	logic [63:0]       chunk_w;
	logic [CNT_W-1:0]  fill_w;

	assign out_full = (rq_cnt_q == 2'd2);
	assign empty    = (rq_cnt_q == 2'd0);
	assign head     = rq_q[rq_rd_q];

	// Assemble the current copy byte
	always_comb begin
		chunk_w    = chunk_q | (64'(rdata_q) << {fill_q[2:0], 3'b000});
		fill_w     = fill_q + CNT_W'(1);
		fin        = (left_q == LEN_W'(1));
		done_chunk = (fill_w == CNT_W'(CHUNK_BYTES)) || fin;
		stall      = rv_q && done_chunk && out_full;
		consume    = (state_q == BK_COPY) && rv_q && !stall;
		rd_en      = (state_q == BK_COPY) && (issue_q != '0) && !stall;
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && cmd.kind == CMD_COPY) begin
					state_n = BK_COPY;
				end
			end
			BK_COPY: begin
				if (consume && fin) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	// Outputs of the engine
	always_comb begin
		cmd_pop  = 1'b0;
		wr_en    = 1'b0;
		load     = 1'b0;
		res_push = 1'b0;
		res_in   = '0;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						CMD_WRITE: begin
							wr_en   = 1'b1;
							cmd_pop = 1'b1;
						end
						CMD_EMIT: begin
							if (!out_full) begin
								res_push      = 1'b1;
								res_in.bytes  = cmd.data;
								res_in.count  = cmd.count;
								res_in.last   = cmd.last;
								res_in.status = cmd.status;
								cmd_pop       = 1'b1;
							end
						end
						CMD_COPY: begin
							load    = 1'b1;
							cmd_pop = 1'b1;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			BK_COPY: begin
				if (consume && done_chunk) begin
					res_push      = 1'b1;
					res_in.bytes  = chunk_w;
					res_in.count  = fill_w;
					res_in.last   = cp_last_q && fin;
					res_in.status = fin ? cp_status_q : ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Base store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cmd.addr] <= cmd.data[7:0];
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr_q];
		end
	end

	// Copy payload
	always_ff @(posedge clk) begin
		if (load) begin
			chunk_q     <= '0;
			fill_q      <= '0;
			cp_last_q   <= cmd.last;
			cp_status_q <= cmd.status;
		end else if (consume) begin
			chunk_q <= done_chunk ? '0 : chunk_w;
			fill_q  <= done_chunk ? '0 : fill_w;
		end
		if (load) begin
			rd_addr_q <= cmd.addr;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
		end
	end

	// Copy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			issue_q <= '0;
			left_q  <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				issue_q <= cmd.len;
				left_q  <= cmd.len;
				rv_q    <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_q <= issue_q - LEN_W'(1);
				end
				if (consume) begin
					left_q <= left_q - LEN_W'(1);
				end
				if (rd_en) begin
					rv_q <= 1'b1;
				end else if (consume) begin
					rv_q <= 1'b0;
				end
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wr_q] <= res_in;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (pop && !empty) begin
				rq_rd_q <= ~rq_rd_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(pop && !empty);
		end
	end

endmodule

/* rtl/pack_delta_apply_core.sv */
// ----------------------------------------------------------------------------
// pack_delta_apply_core
// Applies a pack delta stream to a base object held in a local store.
// ----------------------------------------------------------------------------
// Input channel: a transaction is taken when push is high and full is low.
// action 0 starts a new base, 1 appends a base byte, 2 feeds a delta byte;
// end_of_delta marks the last delta byte. Result channel: while empty is
// low the oldest result sits on out_bytes/byte_count/last/status and is
// taken when pop is high.
// The parser takes one transaction a cycle while the command queue has
// room. A copy occupies the execution engine while it is loaded, while its
// first byte is read and then while it reads one byte a cycle from the single
// read port of the store, holding while the result queue is full.
// A literal chunk or a status result reaches the result ports through the
// command queue and the result queue; the first chunk of a copy also waits
// for the load and the first read, and comes later behind an earlier copy.
// When the receiver stalls, the result queue fills, the engine holds, the
// command queue fills and full rises; nothing is lost.
// Reset clears both queues and the parser; the base store keeps no reset and
// must be reloaded.
// ----------------------------------------------------------------------------
module pack_delta_apply_core import pda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        end_of_delta,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        last,
	output logic [2:0]  status
);

	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_head;
	res_t res_head;

	pda_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (push && !full),
		.action       (action),
		.data_byte    (data_byte),
		.end_of_delta (end_of_delta),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	pda_cmd_queue u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.empty    (cmd_empty),
		.head     (cmd_head)
	);

	pda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.head      (res_head)
	);

	assign full       = cmd_full;
	assign out_bytes  = res_head.bytes;
	assign byte_count = res_head.count;
	assign last       = res_head.last;
	assign status     = res_head.status;

	// A command is never offered to a full queue
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> !cmd_full)
		else $error("command pushed into full queue");

	// A non-zero status only ends an object
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> last)
		else $error("status on a result that is not last");

	// A result never carries more than one chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_count <= 4'(CHUNK_BYTES)))
		else $error("byte count beyond chunk size");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for pack_delta_apply_core. A directed delta comes first, then
// random base loads and deltas: mostly well formed, the rest with header
// mismatches, zero opcodes, out-of-range copies, truncation, abandoned
// deltas, long varints and noise. A local model predicts every result
// chunk, and the monitor compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module tb;
	import pda_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int STIM_ITEMS  = 290;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [1:0] act;
		logic [7:0] dat;
		logic       eod;
	} item_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic        end_of_delta;
	logic        empty;
	logic        pop;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last;
	logic [2:0]  status;

	pack_delta_apply_core DUT (.*);

	item_t  stim_q[$];
	res_t   target_chunks_q[$];
	res_t   step_chunks[$];
	int     n_total;
	int     n_sent;
	int     n_errors;
	int     cycles;
	bit     running;
	bit     took;
	int     send_idle;
	int     recv_idle;

	// generator's view of the current base
	logic [7:0] gen_base [BASE_BYTES];
	int         gen_len;

	// model state
	logic [7:0]  m_store [BASE_BYTES];
	int          m_base_len;
	bit          m_overflow;
	phase_t      m_phase;
	logic [63:0] m_accum;
	int          m_shift;
	logic [63:0] m_target;
	logic [63:0] m_produced;
	logic [6:0]  m_mask;
	logic [31:0] m_offset;
	logic [23:0] m_length;
	logic [6:0]  m_lit_left;
	logic [63:0] m_lit_chunk;

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------
	function automatic void parser_clear();
		m_phase     = PH_BASE_HDR;
		m_accum     = '0;
		m_shift     = 0;
		m_target    = '0;
		m_produced  = '0;
		m_mask      = '0;
		m_offset    = '0;
		m_length    = '0;
		m_lit_left  = '0;
		m_lit_chunk = '0;
	endfunction

	function automatic void add_chunk(logic [63:0] b, int n);
		res_t r;
		r.bytes  = b;
		r.count  = n[3:0];
		r.last   = 1'b0;
		r.status = ST_OK;
		step_chunks.push_back(r);
	endfunction

	function automatic void close_object(logic [2:0] st);
		if (step_chunks.size() == 0)
			add_chunk('0, 0);
		step_chunks[$].last   = 1'b1;
		step_chunks[$].status = st;
	endfunction

	function automatic bit varint_take(logic [7:0] b);
		if (m_shift < 64)
			m_accum |= 64'(b[6:0]) << m_shift;
		if (m_shift < 70)
			m_shift += 7;
		return !b[7];
	endfunction

	function automatic logic [2:0] run_copy();
		int          len;
		int          fill;
		logic [63:0] chunk;
		len   = (m_length == 0) ? 32'h10000 : int'(m_length);
		fill  = 0;
		chunk = '0;
		if (64'(m_offset) + 64'(len) > 64'(m_base_len))
			return ST_COPY_PAST;
		for (int i = 0; i < len; i++) begin
			chunk |= 64'(m_store[(m_offset + i) % BASE_BYTES]) << (8 * fill);
			fill++;
			if (fill == CHUNK_BYTES) begin
				add_chunk(chunk, fill);
				chunk = '0;
				fill  = 0;
			end
		end
		if (fill != 0)
			add_chunk(chunk, fill);
		m_produced += 64'(len);
		m_phase     = PH_OPCODE;
		return ST_OK;
	endfunction

	function automatic logic [2:0] take_delta_byte(logic [7:0] b);
		logic [2:0] pend;
		int         bit_i;
		case (m_phase)
			PH_BASE_HDR: begin
				if (varint_take(b)) begin
					m_length = m_overflow ? 24'(ST_BASE_OVF) :
						(m_accum != 64'(m_base_len) ? 24'(ST_BASE_SIZE) : 24'(ST_OK));
					m_accum  = '0;
					m_shift  = 0;
					m_phase  = PH_TGT_HDR;
				end
				return ST_OK;
			end
			PH_TGT_HDR: begin
				if (varint_take(b)) begin
					pend       = m_length[2:0];
					m_target   = m_accum;
					m_accum    = '0;
					m_shift    = 0;
					m_produced = '0;
					m_length   = '0;
					m_phase    = PH_OPCODE;
					return pend;
				end
				return ST_OK;
			end
			PH_OPCODE: begin
				if (b[7]) begin
					m_mask   = b[6:0];
					m_offset = '0;
					m_length = '0;
					if (m_mask == 0)
						return run_copy();
					m_phase = PH_OPERANDS;
					return ST_OK;
				end
				if (b == 0)
					return ST_OP_ZERO;
				m_lit_left  = b[6:0];
				m_lit_chunk = '0;
				m_mask      = '0;
				m_phase     = PH_LITERAL;
				return ST_OK;
			end
			PH_OPERANDS: begin
				bit_i = 0;
				while (bit_i < 7 && !m_mask[bit_i])
					bit_i++;
				if (bit_i < 4)
					m_offset |= 32'(b) << (8 * bit_i);
				else
					m_length |= 24'(b) << (8 * (bit_i - 4));
				m_mask[bit_i] = 1'b0;
				if (m_mask == 0)
					return run_copy();
				return ST_OK;
			end
			PH_LITERAL: begin
				m_lit_chunk |= 64'(b) << (8 * m_mask);
				m_mask++;
				m_lit_left--;
				m_produced++;
				if (m_mask == CHUNK_BYTES || m_lit_left == 0) begin
					add_chunk(m_lit_chunk, int'(m_mask));
					m_lit_chunk = '0;
					m_mask      = '0;
				end
				if (m_lit_left == 0)
					m_phase = PH_OPCODE;
				return ST_OK;
			end
			default: return ST_OK;
		endcase
	endfunction

	// predict the result chunks of one accepted transaction
	function automatic void apply_delta_step(logic [1:0] act, logic [7:0] b, logic eod);
		logic [2:0] err;
		step_chunks.delete();
		if (act == ACT_START) begin
			m_base_len = 0;
			m_overflow = 1'b0;
			parser_clear();
		end else if (act == ACT_APPEND) begin
			if (m_base_len < BASE_BYTES) begin
				m_store[m_base_len] = b;
				m_base_len++;
			end else begin
				m_overflow = 1'b1;
			end
			parser_clear();
		end else if (act == ACT_DELTA) begin
			if (m_phase == PH_DISCARD) begin
				if (eod)
					parser_clear();
			end else begin
				err = take_delta_byte(b);
				if (err != ST_OK) begin
					close_object(err);
					if (eod)
						parser_clear();
					else
						m_phase = PH_DISCARD;
				end else if (eod) begin
					if (m_phase != PH_OPCODE)
						close_object(ST_TRUNC);
					else
						close_object(m_produced == m_target ? ST_OK : ST_TGT_SIZE);
					parser_clear();
				end
			end
		end
		foreach (step_chunks[i])
			target_chunks_q.push_back(step_chunks[i]);
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic put(logic [1:0] a, logic [7:0] d, logic e);
		item_t it;
		it.act = a;
		it.dat = d;
		it.eod = e;
		stim_q.push_back(it);
	endtask

	task automatic load_base(int n);
		put(ACT_START, 8'($urandom), 1'($urandom));
		gen_len = 0;
		for (int i = 0; i < n; i++) begin
			gen_base[i % BASE_BYTES] = 8'($urandom);
			put(ACT_APPEND, gen_base[i % BASE_BYTES], 1'($urandom));
		end
		gen_len = (n > BASE_BYTES) ? BASE_BYTES : n;
	endtask

	task automatic add_varint(ref logic [7:0] dq[$], input logic [63:0] v, input int pad);
		while (v >= 64'h80 || pad > 0) begin
			dq.push_back({1'b1, v[6:0]});
			if (v < 64'h80)
				pad--;
			v = v >> 7;
		end
		dq.push_back({1'b0, v[6:0]});
	endtask

	task automatic add_copy(ref logic [7:0] ops[$], input int off, input int len);
		logic [7:0] mask;
		logic [7:0] args[$];
		mask = 8'h80;
		for (int k = 0; k < 4; k++)
			if (off[8*k +: 8] != 0 || $urandom_range(3) == 0) begin
				mask[k] = 1'b1;
				args.push_back(off[8*k +: 8]);
			end
		if (len != 32'h10000)
			for (int k = 0; k < 3; k++)
				if (len[8*k +: 8] != 0 || $urandom_range(3) == 0) begin
					mask[4+k] = 1'b1;
					args.push_back(len[8*k +: 8]);
				end
		ops.push_back(mask);
		foreach (args[i])
			ops.push_back(args[i]);
	endtask

	// kinds: 0-5 well formed, 6 base size, 7 target size, 8 zero opcode,
	// 9 copy past base, 10 truncated, 11 abandoned, 12 noise, 13 long varint
	task automatic gen_delta(int kind);
		logic [7:0] dq[$];
		logic [7:0] ops[$];
		int         produced;
		int         n_ops;
		int         off;
		int         len;
		produced = 0;
		n_ops    = $urandom_range(5, 1);
		for (int i = 0; i < n_ops; i++) begin
			if (gen_len > 0 && $urandom_range(1) == 0) begin
				off = $urandom_range(gen_len - 1);
				len = $urandom_range(1, (gen_len - off > 40) ? 40 : gen_len - off);
				if ($urandom_range(9) == 0) begin
					off = 0;
					len = gen_len;
				end
				add_copy(ops, off, len);
				produced += len;
			end else begin
				len = ($urandom_range(7) == 0) ? $urandom_range(127, 1) : $urandom_range(20, 1);
				ops.push_back(8'(len));
				for (int j = 0; j < len; j++)
					ops.push_back(8'($urandom));
				produced += len;
			end
		end
		if (kind == 8)
			ops.insert($urandom_range(ops.size()), 8'h00);
		if (kind == 9) begin
			if ($urandom_range(1) == 0)
				add_copy(ops, 0, 32'h10000);
			else
				add_copy(ops, $urandom_range(gen_len), gen_len + 1 - $urandom_range(gen_len));
		end
		add_varint(dq, (kind == 6) ? 64'(gen_len + $urandom_range(3, 1)) : 64'(gen_len),
			(kind == 13) ? 10 : 0);
		add_varint(dq, (kind == 7) ? 64'(produced + 1) : 64'(produced),
			(kind == 13) ? $urandom_range(10) : 0);
		if (kind == 12) begin
			dq.delete();
			repeat ($urandom_range(12, 1))
				dq.push_back(8'($urandom));
		end else begin
			foreach (ops[i])
				dq.push_back(ops[i]);
		end
		if (kind == 10)
			dq = dq[0 : $urandom_range(dq.size() - 2)];
		foreach (dq[i])
			put(ACT_DELTA, dq[i], (kind != 11) && (i == dq.size() - 1));
	endtask

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		action       = ACT_START;
		data_byte    = '0;
		end_of_delta = 1'b0;
		n_sent       = 0;
		n_errors     = 0;
		cycles       = 0;
		running      = 1'b0;
		took         = 1'b0;
		m_base_len   = 0;
		m_overflow   = 1'b0;
		parser_clear();

		// directed: extreme bytes, full operand mask, both opcode kinds
		put(ACT_START, 8'h00, 1'b0);
		begin
			logic [7:0] bb[$];
			bb = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE};
			foreach (bb[i]) begin
				gen_base[i] = bb[i];
				put(ACT_APPEND, bb[i], 1'b1);
			end
			gen_len = 8;
			bb = '{8'h08, 8'h0C, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00,
				8'h00, 8'h03, 8'hAA, 8'hBB, 8'hCC, 8'h90, 8'h05};
			foreach (bb[i])
				put(ACT_DELTA, bb[i], i == bb.size() - 1);
		end
		put(ACT_NONE, 8'hFF, 1'b1);
		gen_delta(8);
		gen_delta(9);

		// random: mostly well formed, now and then a fresh base
		while (stim_q.size() < STIM_ITEMS) begin
			if ($urandom_range(2) == 0)
				load_base(($urandom_range(5) == 0) ? $urandom_range(100) : $urandom_range(24, 1));
			repeat ($urandom_range(2, 1)) begin
				if ($urandom_range(9) < 6)
					gen_delta($urandom_range(5));
				else
					gen_delta($urandom_range(13, 6));
			end
			if ($urandom_range(9) == 0)
				put(ACT_NONE, 8'($urandom), 1'($urandom));
		end
		n_total = stim_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n  = 1'b1;
		running = 1'b1;

		while (stim_q.size() != 0 || target_chunks_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (n_errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// sender and receiver idle rates per phase
	always_comb begin
		if (n_sent < n_total / 3) begin
			send_idle = 37;
			recv_idle = 54;
		end else if (n_sent < 2 * n_total / 3) begin
			send_idle = 54;
			recv_idle = 37;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// driver: advance on the falling edge
	always @(negedge clk) begin
		if (running) begin
			if (took) begin
				void'(stim_q.pop_front());
				n_sent++;
				took = 1'b0;
			end
			if (stim_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				push         <= 1'b1;
				action       <= stim_q[0].act;
				data_byte    <= stim_q[0].dat;
				end_of_delta <= stim_q[0].eod;
			end else begin
				push <= 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: predict on each input transaction, check each result
	always @(posedge clk) begin
		res_t want;
		if (running && push && !full) begin
			took = 1'b1;
			apply_delta_step(action, data_byte, end_of_delta);
		end
		if (running && pop && !empty) begin
			if (target_chunks_q.size() == 0) begin
				$error("unexpected result: out_bytes %h byte_count %0d", out_bytes, byte_count);
				n_errors++;
			end else begin
				want = target_chunks_q.pop_front();
				if (out_bytes !== want.bytes) begin
					$error("out_bytes: expected %h, got %h", want.bytes, out_bytes);
					n_errors++;
				end
				if (byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count, byte_count);
					n_errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					n_errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_errors++;
				end
			end
		end
	end

	// guard against a hang
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

endmodule

/* files.f */
rtl/pda_pkg.sv
rtl/pda_front.sv
rtl/pda_cmd_queue.sv
rtl/pda_back.sv
rtl/pack_delta_apply_core.sv
test/tb.sv
